// ===== hdl/sckb_pkg.sv =====
// ============================================================================
// sckb_pkg
// Shared types, constants and arithmetic helpers of the scaled sprite blitter.
// ============================================================================
package sckb_pkg;

   localparam int SCREEN_W_DEF     = 320;
   localparam int SCREEN_H_DEF     = 240;
   localparam int SPRITE_DEPTH_DEF = 16384;

   // transparent pixel value (magenta in RGB565)
   localparam logic [15:0] COLOR_KEY = 16'hF81F;

   // quotient bits of one axis divider, one bit per stage
   localparam int QUOT_BITS = 8;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_TARGET_WIDTH  = 3'd2,
      CSR_TARGET_HEIGHT = 3'd3,
      CSR_CROP_LEFT     = 3'd4,
      CSR_CROP_TOP      = 3'd5,
      CSR_CROP_WIDTH    = 3'd6,
      CSR_CROP_HEIGHT   = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_DRAW = 1'b1
   } op_type;

   typedef struct packed {
      logic [7:0] image_width;
      logic [7:0] image_height;
      logic [8:0] target_width;
      logic [8:0] target_height;
      logic [6:0] crop_left;
      logic [6:0] crop_top;
      logic [7:0] crop_width;
      logic [7:0] crop_height;
   } cfg_type;

   // one pipeline slot; later stages fill in the fields they produce
   typedef struct packed {
      op_type      op;
      logic [13:0] ld_idx;
      logic [15:0] ld_val;
      logic        mask_en;
      logic [15:0] mask_color;
      logic [8:0]  scr_x;
      logic [7:0]  scr_y;
      logic [16:0] rem_x;
      logic [16:0] rem_y;
      logic [7:0]  q_x;
      logic [7:0]  q_y;
      logic [7:0]  sx;
      logic [7:0]  sy;
      logic [15:0] lin;
      logic [16:0] qe;
      logic [17:0] res;
   } pipe_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [17:0] div_step(input logic [16:0] rem,
                                            input logic [8:0]  divisor,
                                            input int          shift);
      logic [16:0] d;
      d = 17'(divisor) << shift;
      if (rem >= d) begin
         return {1'b1, 17'(rem - d)};
      end
      return {1'b0, rem};
   endfunction

   // exclusive end of the crop window along one axis
   function automatic logic [7:0] axis_end(input logic [6:0] start,
                                           input logic [7:0] size,
                                           input logic [7:0] img);
      logic [8:0] e;
      e = 9'(start) + 9'(size);
      if (e > 9'(img)) begin
         return img;
      end
      return e[7:0];
   endfunction

   function automatic logic axis_ok(input logic [8:0] off,
                                    input logic [6:0] start,
                                    input logic [7:0] end_v,
                                    input logic [7:0] img,
                                    input logic [8:0] target);
      return (8'(start) < img) && (8'(start) < end_v) &&
             (target != 9'd0) && (off <= target);
   endfunction

   // source coordinate, held inside the window
   function automatic logic [7:0] axis_src(input logic [6:0] start,
                                           input logic [7:0] q,
                                           input logic [7:0] end_v);
      logic [8:0] s;
      s = 9'(start) + 9'(q);
      if (s >= 9'(end_v)) begin
         s = 9'(end_v) - 9'd1;
      end
      return s[7:0];
   endfunction

endpackage

// ===== hdl/scaled_cropped_color_key_blit_top.sv =====
// ============================================================================
// scaled_cropped_color_key_blit_top
// Sprite blitter: loads fill a sprite RAM, draws map a destination offset to
// a scaled, cropped source pixel, drop the color key and clip to the screen.
// ============================================================================
//
//  channel | dir | fields (tdata / tuser, low bit first)
//  --------+-----+------------------------------------------------------------
//  req_    | in  | tuser: opcode; tdata: load_index, load_value, pos_x, pos_y,
//          |     |        dest_col, dest_row, mask_enable, mask_color
//  rsp_    | out | tdata: screen_x, screen_y, color
//  csr_    | in  | we, index, wdata (write only)
//
//  One word per clock sustained while the rsp_ side does not stall. A word
//  passes 15 registers, the first loaded at the accepting edge: 1 entry
//  stage, 8 stages of per-axis restoring division (one quotient bit each),
//  clamp, address multiply, 2 stages of reciprocal modulo, the sprite RAM
//  access and the output register. The single RAM port serves one load or
//  one draw per cycle. Draws that produce nothing become bubbles.
//  Reset (synchronous) restores the register defaults and empties the
//  pipeline; the sprite RAM is not cleared. A stalled rsp_ side holds the
//  output register; req_tready stays high while any bubble is in flight.
//
module scaled_cropped_color_key_blit_top #(
   parameter int SCREEN_W     = sckb_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H     = sckb_pkg::SCREEN_H_DEF,
   parameter int SPRITE_DEPTH = sckb_pkg::SPRITE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // load_index[13:0], load_value[29:14], pos_x[39:30], pos_y[49:40],
   // dest_col[58:50], dest_row[67:59], mask_enable[68], mask_color[84:69]
   input  logic [87:0]             req_tdata,
   // opcode[0]
   input  logic [0:0]              req_tuser,
   // response stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // screen_x[8:0], screen_y[16:9], color[32:17]
   output logic [39:0]             rsp_tdata,
   // register writes
   input  logic                    csr_we,
   input  sckb_pkg::csr_index_type csr_index,
   input  logic [8:0]              csr_wdata
);
   import sckb_pkg::*;

   // pipeline layout
   localparam int NSTG     = 14;
   localparam int ST_CLAMP = QUOT_BITS + 1;
   localparam int ST_LIN   = QUOT_BITS + 2;
   localparam int ST_QEST  = QUOT_BITS + 3;
   localparam int ST_RES   = QUOT_BITS + 4;
   localparam int ST_MEM   = QUOT_BITS + 5;

   localparam int AW = $clog2(SPRITE_DEPTH);

   // floor(2^32 / depth): estimate of lin / depth is low by at most one
   localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(SPRITE_DEPTH);
   localparam logic [32:0] RECIP      = RECIP_WIDE[32:0];
   localparam logic [16:0] DEPTH17    = 17'(SPRITE_DEPTH);
   localparam logic [17:0] DEPTH18    = 18'(SPRITE_DEPTH);
   localparam logic [17:0] DEPTH2     = 18'(2 * SPRITE_DEPTH);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[7:0];
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata[7:0];
            CSR_TARGET_WIDTH:  cfg_in.target_width  = csr_wdata;
            CSR_TARGET_HEIGHT: cfg_in.target_height = csr_wdata;
            CSR_CROP_LEFT:     cfg_in.crop_left     = csr_wdata[6:0];
            CSR_CROP_TOP:      cfg_in.crop_top      = csr_wdata[6:0];
            CSR_CROP_WIDTH:    cfg_in.crop_width    = csr_wdata[7:0];
            CSR_CROP_HEIGHT:   cfg_in.crop_height   = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= 8'd128;
         cfg_ff.image_height  <= 8'd128;
         cfg_ff.target_width  <= 9'd128;
         cfg_ff.target_height <= 9'd128;
         cfg_ff.crop_left     <= 7'd0;
         cfg_ff.crop_top      <= 7'd0;
         cfg_ff.crop_width    <= 8'd128;
         cfg_ff.crop_height   <= 8'd128;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // crop window ends; the user changes registers only while idle, the block does not enforce it
   logic [7:0] end_x, end_y;
   assign end_x = axis_end(cfg_ff.crop_left, cfg_ff.crop_width, cfg_ff.image_width);
   assign end_y = axis_end(cfg_ff.crop_top, cfg_ff.crop_height, cfg_ff.image_height);

   // ---------------------------------------------------------------------
   // request unpacking and entry checks
   // ---------------------------------------------------------------------
   logic [13:0] in_idx;
   logic [15:0] in_val;
   logic [9:0]  in_pos_x, in_pos_y;
   logic [8:0]  in_col, in_row;
   logic        in_mask_en;
   logic [15:0] in_mask_color;

   assign in_idx        = req_tdata[13:0];
   assign in_val        = req_tdata[29:14];
   assign in_pos_x      = req_tdata[39:30];
   assign in_pos_y      = req_tdata[49:40];
   assign in_col        = req_tdata[58:50];
   assign in_row        = req_tdata[67:59];
   assign in_mask_en    = req_tdata[68];
   assign in_mask_color = req_tdata[84:69];

   // screen position, sign extended
   logic [13:0] sum_x, sum_y;
   logic        on_x, on_y, ok_x, ok_y, in_draw;

   assign sum_x = {{4{in_pos_x[9]}}, in_pos_x} + {5'd0, in_col};
   assign sum_y = {{4{in_pos_y[9]}}, in_pos_y} + {5'd0, in_row};
   assign on_x  = !sum_x[13] && (sum_x < 14'(SCREEN_W));
   assign on_y  = !sum_y[13] && (sum_y < 14'(SCREEN_H));
   assign ok_x  = axis_ok(in_col, cfg_ff.crop_left, end_x, cfg_ff.image_width,
                          cfg_ff.target_width);
   assign ok_y  = axis_ok(in_row, cfg_ff.crop_top, end_y, cfg_ff.image_height,
                          cfg_ff.target_height);
   assign in_draw = (op_type'(req_tuser[0]) == OP_DRAW);

   // ---------------------------------------------------------------------
   // pipeline: slots, valid bits, per-stage enables
   // ---------------------------------------------------------------------
   pipe_type          stg_ff [NSTG];
   pipe_type          stg_in [NSTG];
   logic [NSTG-1:0]   valid_ff, valid_in;
   logic [NSTG:0]     en;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [39:0]       rsp_data_ff, rsp_data_in;
   logic [15:0]       rdata_ff;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              mem_we;

   // a stage moves when it is empty or its successor moves
   always_comb begin
      en[NSTG] = !rsp_valid_ff || rsp_tready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   always_comb begin : pipe_next
      logic [17:0] step_x, step_y;
      logic [48:0] prod_w;

      // entry
      stg_in[0]            = '0;
      stg_in[0].op         = op_type'(req_tuser[0]);
      stg_in[0].ld_idx     = in_idx;
      stg_in[0].ld_val     = in_val;
      stg_in[0].mask_en    = in_mask_en;
      stg_in[0].mask_color = in_mask_color;
      stg_in[0].scr_x      = sum_x[8:0];
      stg_in[0].scr_y      = sum_y[7:0];
      stg_in[0].rem_x      = 17'(in_col) * 17'(cfg_ff.crop_width);
      stg_in[0].rem_y      = 17'(in_row) * 17'(cfg_ff.crop_height);
      valid_in[0] = req_tvalid && (!in_draw || (ok_x && ok_y && on_x && on_y));

      // offset * crop / target, most significant quotient bit first
      for (int k = 1; k <= QUOT_BITS; k++) begin
         stg_in[k] = stg_ff[k-1];
         step_x = div_step(stg_ff[k-1].rem_x, cfg_ff.target_width, QUOT_BITS - k);
         step_y = div_step(stg_ff[k-1].rem_y, cfg_ff.target_height, QUOT_BITS - k);
         stg_in[k].rem_x              = step_x[16:0];
         stg_in[k].q_x[QUOT_BITS - k] = step_x[17];
         stg_in[k].rem_y              = step_y[16:0];
         stg_in[k].q_y[QUOT_BITS - k] = step_y[17];
         valid_in[k] = valid_ff[k-1];
      end

      stg_in[ST_CLAMP]    = stg_ff[ST_CLAMP-1];
      stg_in[ST_CLAMP].sx = axis_src(cfg_ff.crop_left, stg_ff[ST_CLAMP-1].q_x, end_x);
      stg_in[ST_CLAMP].sy = axis_src(cfg_ff.crop_top, stg_ff[ST_CLAMP-1].q_y, end_y);
      valid_in[ST_CLAMP]  = valid_ff[ST_CLAMP-1];

      stg_in[ST_LIN]     = stg_ff[ST_CLAMP];
      stg_in[ST_LIN].lin = 16'({8'd0, stg_ff[ST_CLAMP].sy} * {8'd0, cfg_ff.image_width})
                           + 16'(stg_ff[ST_CLAMP].sx);
      valid_in[ST_LIN]   = valid_ff[ST_CLAMP];

      prod_w = 49'(stg_ff[ST_LIN].lin) * 49'(RECIP);
      stg_in[ST_QEST]    = stg_ff[ST_LIN];
      stg_in[ST_QEST].qe = prod_w[48:32];
      valid_in[ST_QEST]  = valid_ff[ST_LIN];

      stg_in[ST_RES]     = stg_ff[ST_QEST];
      stg_in[ST_RES].res = 18'(stg_ff[ST_QEST].lin) - 18'(stg_ff[ST_QEST].qe * DEPTH17);
      valid_in[ST_RES]   = valid_ff[ST_QEST];

      // loads end at the RAM; only draws go on
      stg_in[ST_MEM]   = stg_ff[ST_RES];
      valid_in[ST_MEM] = valid_ff[ST_RES] && (stg_ff[ST_RES].op == OP_DRAW);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (en[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // sprite RAM: loads and draw reads meet at the same stage, so program
   // order holds without forwarding
   // ---------------------------------------------------------------------
   logic [17:0] res_fix;
   logic [15:0] sprite_mem [SPRITE_DEPTH];

   assign res_fix = (stg_ff[ST_RES].res >= DEPTH18) ? stg_ff[ST_RES].res - DEPTH18
                                                    : stg_ff[ST_RES].res;
   assign rd_addr = AW'(res_fix);
   assign wr_addr = AW'(stg_ff[ST_RES].ld_idx);
   assign mem_we  = en[ST_MEM] && valid_ff[ST_RES] && (stg_ff[ST_RES].op == OP_LOAD) &&
                    (17'(stg_ff[ST_RES].ld_idx) < DEPTH17);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sprite_mem[wr_addr] <= stg_ff[ST_RES].ld_val;
      end
      if (en[ST_MEM]) begin
         rdata_ff <= sprite_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // color key, mask and output register
   // ---------------------------------------------------------------------
   logic [15:0] out_color;

   assign out_color    = stg_ff[ST_MEM].mask_en ? stg_ff[ST_MEM].mask_color : rdata_ff;
   assign rsp_valid_in = valid_ff[ST_MEM] && (rdata_ff != COLOR_KEY);
   assign rsp_data_in  = {7'd0, out_color, stg_ff[ST_MEM].scr_y, stg_ff[ST_MEM].scr_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[NSTG]) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTG]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // clipped coordinates only
   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_data_ff[8:0]) < SCREEN_W) &&
                       (32'(rsp_data_ff[16:9]) < SCREEN_H))
      else $error("response outside the screen");

   // reciprocal estimate leaves at most one correction
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_RES] |-> (stg_ff[ST_RES].res < DEPTH2))
      else $error("modulo residue out of range");

   // read data held while the RAM stage is stalled
   a_rdata_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_MEM] && !en[ST_MEM] |=> $stable(rdata_ff))
      else $error("sprite read data lost under stall");

   // a response comes only from a draw at the RAM stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_ff[ST_MEM]))
      else $error("response without a draw behind it");

endmodule

// ===== verif/scaled_cropped_color_key_blit_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// scaled_cropped_color_key_blit_top_tb
// Self-checking bench for the sprite blitter. A short directed table covers
// field extremes, clamping, the color key, masking and screen clipping, then
// register settings are swept with random load/draw traffic. Every accepted
// request word is run through a local pixel predictor; response words are
// compared in order against the predicted pixels.
// ============================================================================
module scaled_cropped_color_key_blit_top_tb;
   import sckb_pkg::*;

   localparam int DRAIN_CYCLES = 20;   // pipeline is 15 deep, plus margin

   // how a directed row is checked
   typedef enum logic [1:0] {BY_MODEL, NO_PIXEL, PIXEL} pixel_check_type;

   // matches rsp_tdata from bit 0 up: screen_x, screen_y, color
   typedef struct packed {
      logic [15:0] color;
      logic [7:0]  y;
      logic [8:0]  x;
   } pixel_type;

   typedef struct packed {
      op_type            op;
      logic [13:0]       idx;
      logic [15:0]       val;
      logic signed [9:0] px;
      logic signed [9:0] py;
      logic [8:0]        col;
      logic [8:0]        row;
      logic              men;
      logic [15:0]       mcol;
      pixel_check_type   chk;
      pixel_type         pix;   // {color, y, x}
   } blit_row_type;

   localparam pixel_type NO_PIX = '0;

   // Directed stimulus under the reset settings: 128x128 image, full crop,
   // 128x128 target, so the scale is one to one and offset 128 clamps to 127.
   localparam int N_DIRECTED = 23;
   localparam blit_row_type DIRECTED [N_DIRECTED] = '{
      // seed the few sprite entries the draws below read
      '{OP_LOAD, 0,     16'h1234, 0, 0, 0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_LOAD, 16383, 16'hFFFF, 0, 0, 0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_LOAD, 1,     COLOR_KEY, 0, 0, 0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_LOAD, 127,   16'h0000, 0, 0, 0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_LOAD, 16256, 16'hABCD, 0, 0, 0, 0, 0, 0, NO_PIXEL, NO_PIX},
      // origin, key drop, far corner, clamp at offset == target
      '{OP_DRAW, 0, 0, 0, 0, 0,   0,   0, 0, PIXEL, '{16'h1234, 8'd0, 9'd0}},
      '{OP_DRAW, 0, 0, 0, 0, 1,   0,   0, 0, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, 0, 0, 127, 127, 0, 0, PIXEL, '{16'hFFFF, 8'd127, 9'd127}},
      '{OP_DRAW, 0, 0, 0, 0, 128, 128, 0, 0, PIXEL, '{16'hFFFF, 8'd128, 9'd128}},
      // offsets past the target area
      '{OP_DRAW, 14'h3FFF, 16'hFFFF, 0, 0, 129, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, 0, 0, 320, 320, 0, 0, NO_PIXEL, NO_PIX},
      // screen clipping on all four sides, position extremes
      '{OP_DRAW, 0, 0, -512, 0,  0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, 511,  0,  0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, -1,   0,  0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, 0,    -1, 0, 0, 0, 0, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, 319, 239, 0, 0, 0, 0, PIXEL, '{16'h1234, 8'd239, 9'd319}},
      '{OP_DRAW, 0, 0, 192,  0,  128, 0,   0, 0, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, 0,    112, 0,  128, 0, 0, NO_PIXEL, NO_PIX},
      // masking replaces opaque pixels only
      '{OP_DRAW, 0, 0, 0, 0, 0,   0, 1, 16'hFFFF, PIXEL, '{16'hFFFF, 8'd0, 9'd0}},
      '{OP_DRAW, 0, 0, 0, 0, 127, 0, 1, 16'h07E0, PIXEL, '{16'h07E0, 8'd0, 9'd127}},
      '{OP_DRAW, 0, 0, 0, 0, 1,   0, 1, 16'h001F, NO_PIXEL, NO_PIX},
      '{OP_DRAW, 0, 0, -128, -128, 128, 128, 0, 0, BY_MODEL, NO_PIX},
      '{OP_DRAW, 0, 0, 100, 50, 0, 128, 1, 16'hA5A5, BY_MODEL, NO_PIX}
   };

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [87:0]         req_tdata   = '0;
   logic [0:0]          req_tuser   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                csr_we      = 1'b0;
   csr_index_type       csr_index   = CSR_IMAGE_WIDTH;
   logic [8:0]          csr_wdata   = '0;

   // percent of cycles each side holds off
   int                  tx_gap      = 19;
   int                  rx_stall    = 52;
   int                  mismatches  = 0;

   // predictor state: register copy, sprite image, which entries hold data
   cfg_type             blit_cfg;
   logic [15:0]         sprite_img [SPRITE_DEPTH_DEF];
   bit                  loaded     [SPRITE_DEPTH_DEF];
   pixel_type           expected_pixels [$];

   scaled_cropped_color_key_blit_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, re-rolled every cycle
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= rx_stall);
   end

   function automatic cfg_type mk_cfg(input int iw, ih, tw, th, cl, ct, cw, ch);
      cfg_type c;
      c.image_width   = 8'(iw);
      c.image_height  = 8'(ih);
      c.target_width  = 9'(tw);
      c.target_height = 9'(th);
      c.crop_left     = 7'(cl);
      c.crop_top      = 7'(ct);
      c.crop_width    = 8'(cw);
      c.crop_height   = 8'(ch);
      return c;
   endfunction

   function automatic cfg_type random_cfg();
      int iw;
      int ih;
      iw = $urandom_range(1, 128);
      ih = $urandom_range(1, 128);
      return mk_cfg(iw, ih, $urandom_range(1, 320), $urandom_range(1, 320),
                    $urandom_range(0, iw - 1), $urandom_range(0, ih - 1),
                    $urandom_range(1, 128), $urandom_range(1, 128));
   endfunction

   // tdata from bit 0: load_index, load_value, pos_x, pos_y, dest_col,
   // dest_row, mask_enable, mask_color, zero pad
   function automatic logic [87:0] pack_req(input logic [13:0] idx,
                                            input logic [15:0] val,
                                            input logic [9:0]  px, py,
                                            input logic [8:0]  col, row,
                                            input logic        men,
                                            input logic [15:0] mcol);
      return {3'b000, mcol, men, row, col, py, px, val, idx};
   endfunction

   // sprite loads are keyed now and then so the key drop keeps firing
   function automatic logic [15:0] random_pixel();
      return ($urandom_range(0, 7) == 0) ? COLOR_KEY : 16'($urandom);
   endfunction

   // Nearest-neighbor step along one axis: start + floor(off*size/target),
   // held inside the crop window. Zero means nothing is drawn.
   function automatic bit scale_axis(input int unsigned off, start, size, img,
                                     target, output int unsigned src);
      int unsigned stop;
      stop = start + size;
      if (stop > img) stop = img;
      src = 0;
      if (start >= img || start >= stop || target == 0 || off > target) return 0;
      src = start + (off * size) / target;
      if (src >= stop) src = stop - 1;
      return 1;
   endfunction

   // sprite entry a draw at this offset reads, if it reads one at all
   function automatic bit source_addr(input int unsigned col, row,
                                      output int unsigned addr);
      int unsigned sx;
      int unsigned sy;
      addr = 0;
      if (!scale_axis(col, 32'(blit_cfg.crop_left), 32'(blit_cfg.crop_width),
                      32'(blit_cfg.image_width), 32'(blit_cfg.target_width), sx))
         return 0;
      if (!scale_axis(row, 32'(blit_cfg.crop_top), 32'(blit_cfg.crop_height),
                      32'(blit_cfg.image_height), 32'(blit_cfg.target_height), sy))
         return 0;
      addr = (sx + sy * blit_cfg.image_width) % SPRITE_DEPTH_DEF;
      return 1;
   endfunction

   // Applies one accepted word to the local image; returns 1 and the pixel
   // when a draw writes to the screen.
   function automatic bit blit_pixel(input op_type op, input logic [87:0] w,
                                     output pixel_type p);
      int unsigned addr;
      int          scr_x;
      int          scr_y;
      logic [15:0] src;
      p = '0;
      if (op == OP_LOAD) begin
         sprite_img[w[13:0]] = w[29:14];
         loaded[w[13:0]]     = 1'b1;
         return 0;
      end
      if (!source_addr(32'(w[58:50]), 32'(w[67:59]), addr)) return 0;
      if (!loaded[addr]) begin
         $display("%0t: draw reads sprite entry %0d that was never loaded", $time, addr);
         mismatches++;
      end
      src = sprite_img[addr];
      if (src == COLOR_KEY) return 0;
      scr_x = int'($signed(w[39:30])) + int'(w[58:50]);
      scr_y = int'($signed(w[49:40])) + int'(w[67:59]);
      if (scr_x < 0 || scr_x >= SCREEN_W_DEF || scr_y < 0 || scr_y >= SCREEN_H_DEF)
         return 0;
      p.x     = 9'(scr_x);
      p.y     = 8'(scr_y);
      p.color = w[68] ? w[84:69] : src;
      return 1;
   endfunction

   // Presents one word and holds it until taken. Entered and left just after
   // a falling edge; tvalid stays high when the next word follows at once.
   task automatic send_word(input op_type op, input logic [87:0] w,
                            input pixel_check_type chk, input pixel_type typed);
      pixel_type p;
      bit        hit;
      while ($urandom_range(0, 99) < tx_gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit = blit_pixel(op, w, p);
      if (chk == PIXEL) begin
         expected_pixels.push_back(typed);
      end else if (chk == BY_MODEL && hit) begin
         expected_pixels.push_back(p);
      end
      @(negedge clock);
   endtask

   // Sender holds off until every predicted pixel is back, then lets the
   // load-only tail of the pipeline run dry.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes all eight registers back to back; block is idle here.
   task automatic program_blit(input cfg_type c);
      csr_index_type r;
      logic [8:0]    v;
      r = r.first();
      repeat (r.num()) begin
         case (r)
            CSR_IMAGE_WIDTH:   v = 9'(c.image_width);
            CSR_IMAGE_HEIGHT:  v = 9'(c.image_height);
            CSR_TARGET_WIDTH:  v = c.target_width;
            CSR_TARGET_HEIGHT: v = c.target_height;
            CSR_CROP_LEFT:     v = 9'(c.crop_left);
            CSR_CROP_TOP:      v = 9'(c.crop_top);
            CSR_CROP_WIDTH:    v = 9'(c.crop_width);
            default:           v = 9'(c.crop_height);
         endcase
         csr_we    <= 1'b1;
         csr_index <= r;
         csr_wdata <= v;
         @(negedge clock);
         r = r.next();
      end
      csr_we   <= 1'b0;
      blit_cfg  = c;
   endtask

   // One random item: mostly a draw aimed inside the target and onto the
   // screen, preceded by a load whenever the source entry is still empty.
   task automatic random_item();
      int          col;
      int          row;
      int          px;
      int          py;
      int unsigned addr;
      if ($urandom_range(0, 99) < 15) begin
         send_word(OP_LOAD, pack_req(14'($urandom), random_pixel(), 10'($urandom),
                   10'($urandom), 9'($urandom), 9'($urandom), 1'($urandom),
                   16'($urandom)), BY_MODEL, NO_PIX);
      end else begin
         col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, blit_cfg.target_width)
                                            : $urandom_range(0, 320);
         row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, blit_cfg.target_height)
                                            : $urandom_range(0, 320);
         px  = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 319)) - col
                                            : int'($urandom_range(0, 1023)) - 512;
         py  = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 239)) - row
                                            : int'($urandom_range(0, 1023)) - 512;
         if (source_addr(col, row, addr) && (!loaded[addr] || $urandom_range(0, 3) == 0))
            send_word(OP_LOAD, pack_req(14'(addr), random_pixel(), 10'($urandom),
                      10'($urandom), 9'($urandom), 9'($urandom), 1'($urandom),
                      16'($urandom)), BY_MODEL, NO_PIX);
         send_word(OP_DRAW, pack_req(14'($urandom), 16'($urandom), 10'(px), 10'(py),
                   9'(col), 9'(row), $urandom_range(0, 3) == 0, 16'($urandom)),
                   BY_MODEL, NO_PIX);
      end
   endtask

   task automatic run_phase(input cfg_type c, input int n_items, input int tx,
                            input int rx);
      drain_pipeline();
      program_blit(c);
      tx_gap   = tx;
      rx_stall = rx;
      repeat (n_items) random_item();
   endtask

   // response check: in order, field by field
   always @(posedge clock) begin : check_pixels
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[32:0];
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel expected none, got x=%0d y=%0d color=%h",
                     $time, got.x, got.y, got.color);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.color !== want.color) begin
               $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h, got x=%0d y=%0d color=%h",
                        $time, want.x, want.y, want.color, got.x, got.y, got.color);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      int i;
      blit_cfg = mk_cfg(128, 128, 128, 128, 0, 0, 128, 128);
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed table; sender 19%, receiver 52% idle
      for (i = 0; i < N_DIRECTED; i++) begin
         send_word(DIRECTED[i].op,
                   pack_req(DIRECTED[i].idx, DIRECTED[i].val, DIRECTED[i].px,
                            DIRECTED[i].py, DIRECTED[i].col, DIRECTED[i].row,
                            DIRECTED[i].men, DIRECTED[i].mcol),
                   DIRECTED[i].chk, DIRECTED[i].pix);
      end

      // sender lightly idle, receiver stalling half the time
      run_phase(mk_cfg(128, 128, 320, 320, 0, 0, 128, 128), 25, 19, 52);  // max upscale
      run_phase(mk_cfg(128, 128, 1, 1, 0, 0, 128, 128), 35, 19, 52);      // max downscale
      run_phase(mk_cfg(90, 128, 300, 17, 20, 100, 128, 0), 10, 19, 52);   // zero crop height
      run_phase(mk_cfg(1, 1, 320, 240, 0, 0, 1, 1), 35, 19, 52);          // one-pixel image
      run_phase(mk_cfg(100, 60, 37, 200, 10, 5, 0, 40), 10, 19, 52);      // zero crop width

      // roles swapped
      run_phase(mk_cfg(100, 60, 37, 200, 10, 5, 50, 40), 30, 52, 19);     // mixed scale
      run_phase(mk_cfg(64, 64, 0, 64, 0, 0, 64, 64), 10, 52, 19);         // zero target width
      run_phase(mk_cfg(64, 64, 64, 0, 0, 0, 64, 64), 10, 52, 19);         // zero target height
      run_phase(mk_cfg(128, 128, 64, 64, 127, 127, 128, 128), 35, 52, 19);// window clipped at edge

      // no idling on either side
      run_phase(mk_cfg(50, 50, 100, 100, 60, 0, 10, 10), 10, 0, 0);       // crop left past image
      run_phase(mk_cfg(50, 20, 100, 100, 0, 60, 10, 10), 10, 0, 0);       // crop top past image
      repeat (3) run_phase(random_cfg(), 25, 0, 0);

      drain_pipeline();
      if (mismatches == 0) begin
         $display("scaled_cropped_color_key_blit_top_tb OK");
      end else begin
         $display("scaled_cropped_color_key_blit_top_tb NOT OK");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run (~450 words, heavy stalls)
   initial begin : watchdog
      #2_000_000;
      $display("scaled_cropped_color_key_blit_top_tb NOT OK");
      $finish;
   end

endmodule
